// ===== sv/part_pkg.sv =====
// Package for the pending acknowledgment retry table: word codes, table entry
// layout, request latch layout, controller states and size constants.
// No dependencies; used by pending_ack_retry_table.
package part_pkg;

   localparam int unsigned TABLE_SLOTS_DEF = 8;
   localparam int unsigned SCAN_MAX        = 8;
   localparam int unsigned CNT_W           = $clog2(SCAN_MAX + 1);
   localparam int unsigned TIME_W          = 48;

   typedef enum logic [1:0] {
      REQ_SEND = 2'd0,
      REQ_ACK  = 2'd1,
      REQ_SCAN = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_SEND        = 3'd0,
      EV_DONE_ACKED  = 3'd1,
      EV_DONE_FAILED = 3'd2,
      EV_NO_SLOT     = 3'd3,
      EV_ACK_OK      = 3'd4,
      EV_ACK_UNEXP   = 3'd5,
      EV_SCAN_DONE   = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_ACK_SEL,
      ST_ACK_CHK,
      ST_SCAN_SEL,
      ST_SCAN_CHK,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [31:0]        ack_id;
      logic [TIME_W-1:0]  deadline;
      logic [7:0]         tries;
      logic [7:0]         limit;
      logic [15:0]        wait_ms;
      logic signed [31:0] reply;
      logic [3:0]         owner;
      logic [15:0]        ctx;
      logic               chan;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [7:0]         max_tries;
      logic [15:0]        wait_ms;
      logic signed [31:0] reply;
      logic [3:0]         owner;
      logic [15:0]        ctx;
      logic               chan;
      logic [31:0]        ack_in;
   } request_type;

endpackage

// ===== sv/part_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies; holds the table entries of pending_ack_retry_table.
module part_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 8,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pending_ack_retry_table.sv =====
// Pending acknowledgment retry table: slot entries in part_ram, used and acked
// flags in flops, a sequencer for send, acknowledgment and scan requests.
// Depends on part_pkg and part_ram.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | request (type, time, reply data, ack id)
//   rsp_    | out       | rsp_valid/rsp_stall | event with entry fields, last on final word
//
// One request at a time; req_stall holds new requests off until idle. Send:
// one word. Acknowledgment: used slots are read and compared, free ones are
// skipped; ends on the match or, if none matches, an unexpected-ack word.
// Scan: same walk, stopping after 8 entry words, then the done word; back to
// idle. The single RAM read port sets the walk rate. Reset is synchronous and
// clears flags, id counter and state; RAM contents need no clearing. A stalled
// rsp_ side holds the sequencer on the word it is about to issue.
module pending_ack_retry_table #(
   parameter int unsigned TABLE_SLOTS = part_pkg::TABLE_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [47:0]        req_now_ms,
   input  logic [7:0]         req_max_tries,
   input  logic [15:0]        req_wait_ms,
   input  logic signed [31:0] req_reply_id,
   input  logic [3:0]         req_server_index,
   input  logic [15:0]        req_context_tag,
   input  logic               req_is_channel,
   input  logic [31:0]        req_ack_id_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_res,
   output logic [31:0]        rsp_ack_id,
   output logic signed [31:0] rsp_out_reply_id,
   output logic [3:0]         rsp_out_server,
   output logic [15:0]        rsp_out_context,
   output logic               rsp_out_channel,
   output logic [7:0]         rsp_try_count,
   output logic               rsp_last
);

   localparam int unsigned ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned PTR_W  = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned CNT_W  = part_pkg::CNT_W;
   localparam int unsigned TIME_W = part_pkg::TIME_W;

   part_pkg::state_type   state_ff, state_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [TABLE_SLOTS-1:0] acked_ff, acked_in;
   logic [31:0]           id_ctr_ff, id_ctr_in;
   part_pkg::request_type rq_ff, rq_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   part_pkg::event_type   ev_ff, ev_in;
   logic [31:0]           oid_ff, oid_in;
   logic signed [31:0]    orep_ff, orep_in;
   logic [3:0]            osrv_ff, osrv_in;
   logic [15:0]           octx_ff, octx_in;
   logic                  och_ff, och_in;
   logic [7:0]            otry_ff, otry_in;
   logic                  olast_ff, olast_in;

   logic                  accept;
   logic                  out_free;
   logic                  emit;
   logic                  emit_go;
   part_pkg::event_type   e_ev;
   logic [31:0]           e_id;
   logic signed [31:0]    e_rep;
   logic [3:0]            e_srv;
   logic [15:0]           e_ctx;
   logic                  e_ch;
   logic [7:0]            e_try;
   logic                  e_last;

   logic [ADDR_W-1:0]     idx;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   part_pkg::entry_type   wr_entry;
   part_pkg::entry_type   rd_entry;

   logic                  free_found;
   logic [ADDR_W-1:0]     free_idx;
   logic [31:0]           id_next;
   logic                  ptr_end;
   logic                  overdue;
   logic                  retry;
   logic [TIME_W-1:0]     retry_dl;

   part_ram #(
      .WIDTH ($bits(part_pkg::entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx),
      .rd_data (rd_entry)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != part_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = emit && out_free;
   assign idx       = ptr_ff[ADDR_W-1:0];
   assign ptr_end   = (ptr_ff == PTR_W'(TABLE_SLOTS));
   assign id_next   = (id_ctr_ff == 32'hFFFF_FFFF) ? 32'd1 : id_ctr_ff + 32'd1;
   assign overdue   = (rd_entry.deadline < rq_ff.now_ms);
   assign retry     = (rd_entry.tries < rd_entry.limit);
   assign retry_dl  = rq_ff.now_ms + TIME_W'(rd_entry.wait_ms);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = ADDR_W'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      acked_in  = acked_ff;
      id_ctr_in = id_ctr_ff;
      rq_in     = rq_ff;
      emit      = 1'b0;
      e_ev      = part_pkg::EV_SCAN_DONE;
      e_id      = '0;
      e_rep     = '0;
      e_srv     = '0;
      e_ctx     = '0;
      e_ch      = 1'b0;
      e_try     = '0;
      e_last    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx;
      wr_entry  = rd_entry;

      case (state_ff)
         part_pkg::ST_IDLE: begin
            if (accept) begin
               rq_in.now_ms    = req_now_ms;
               rq_in.max_tries = req_max_tries;
               rq_in.wait_ms   = req_wait_ms;
               rq_in.reply     = req_reply_id;
               rq_in.owner     = req_server_index;
               rq_in.ctx       = req_context_tag;
               rq_in.chan      = req_is_channel;
               rq_in.ack_in    = req_ack_id_in;
               ptr_in          = '0;
               cnt_in          = '0;
               case (part_pkg::req_kind_type'(req_type))
                  part_pkg::REQ_SEND: state_in = part_pkg::ST_SEND;
                  part_pkg::REQ_ACK:  state_in = part_pkg::ST_ACK_SEL;
                  part_pkg::REQ_SCAN: state_in = part_pkg::ST_SCAN_SEL;
                  default:            state_in = part_pkg::ST_FINAL;
               endcase
            end
         end

         part_pkg::ST_SEND: begin
            emit   = 1'b1;
            e_last = 1'b1;
            if (rq_ff.max_tries == 8'd0) begin
               e_ev  = part_pkg::EV_SEND;
               e_rep = rq_ff.reply;
               e_srv = rq_ff.owner;
               e_ctx = rq_ff.ctx;
               e_ch  = rq_ff.chan;
               e_try = 8'd1;
            end else if (!free_found) begin
               e_ev = part_pkg::EV_NO_SLOT;
            end else begin
               e_ev              = part_pkg::EV_SEND;
               e_id              = id_next;
               e_rep             = rq_ff.reply;
               e_srv             = rq_ff.owner;
               e_ctx             = rq_ff.ctx;
               e_ch              = rq_ff.chan;
               e_try             = 8'd1;
               wr_addr           = free_idx;
               wr_entry.ack_id   = id_next;
               wr_entry.deadline = rq_ff.now_ms + TIME_W'(rq_ff.wait_ms);
               wr_entry.tries    = 8'd1;
               wr_entry.limit    = rq_ff.max_tries;
               wr_entry.wait_ms  = rq_ff.wait_ms;
               wr_entry.reply    = rq_ff.reply;
               wr_entry.owner    = rq_ff.owner;
               wr_entry.ctx      = rq_ff.ctx;
               wr_entry.chan     = rq_ff.chan;
               if (emit_go) begin
                  wr_en              = 1'b1;
                  used_in[free_idx]  = 1'b1;
                  acked_in[free_idx] = 1'b0;
                  id_ctr_in          = id_next;
               end
            end
            if (emit_go) begin
               state_in = part_pkg::ST_IDLE;
            end
         end

         part_pkg::ST_ACK_SEL: begin
            if (ptr_end) begin
               emit   = 1'b1;
               e_ev   = part_pkg::EV_ACK_UNEXP;
               e_id   = rq_ff.ack_in;
               e_last = 1'b1;
               if (emit_go) begin
                  state_in = part_pkg::ST_IDLE;
               end
            end else if (!used_ff[idx]) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end else begin
               state_in = part_pkg::ST_ACK_CHK;
            end
         end

         part_pkg::ST_ACK_CHK: begin
            if (rd_entry.ack_id == rq_ff.ack_in) begin
               emit   = 1'b1;
               e_ev   = part_pkg::EV_ACK_OK;
               e_id   = rd_entry.ack_id;
               e_rep  = rd_entry.reply;
               e_srv  = rd_entry.owner;
               e_ctx  = rd_entry.ctx;
               e_ch   = rd_entry.chan;
               e_try  = rd_entry.tries;
               e_last = 1'b1;
               if (emit_go) begin
                  acked_in[idx] = 1'b1;
                  state_in      = part_pkg::ST_IDLE;
               end
            end else begin
               ptr_in   = ptr_ff + PTR_W'(1);
               state_in = part_pkg::ST_ACK_SEL;
            end
         end

         part_pkg::ST_SCAN_SEL: begin
            if (ptr_end || cnt_ff == CNT_W'(part_pkg::SCAN_MAX)) begin
               state_in = part_pkg::ST_FINAL;
            end else if (!used_ff[idx]) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end else begin
               state_in = part_pkg::ST_SCAN_CHK;
            end
         end

         part_pkg::ST_SCAN_CHK: begin
            e_id  = rd_entry.ack_id;
            e_rep = rd_entry.reply;
            e_srv = rd_entry.owner;
            e_ctx = rd_entry.ctx;
            e_ch  = rd_entry.chan;
            e_try = rd_entry.tries;
            if (acked_ff[idx]) begin
               emit = 1'b1;
               e_ev = part_pkg::EV_DONE_ACKED;
               if (emit_go) begin
                  used_in[idx]  = 1'b0;
                  acked_in[idx] = 1'b0;
               end
            end else if (overdue) begin
               emit = 1'b1;
               if (retry) begin
                  e_ev              = part_pkg::EV_SEND;
                  e_try             = rd_entry.tries + 8'd1;
                  wr_entry.tries    = rd_entry.tries + 8'd1;
                  wr_entry.deadline = retry_dl;
                  wr_en             = emit_go;
               end else begin
                  e_ev = part_pkg::EV_DONE_FAILED;
                  if (emit_go) begin
                     used_in[idx] = 1'b0;
                  end
               end
            end
            if (!emit) begin
               ptr_in   = ptr_ff + PTR_W'(1);
               state_in = part_pkg::ST_SCAN_SEL;
            end else if (emit_go) begin
               ptr_in   = ptr_ff + PTR_W'(1);
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = part_pkg::ST_SCAN_SEL;
            end
         end

         part_pkg::ST_FINAL: begin
            emit   = 1'b1;
            e_ev   = part_pkg::EV_SCAN_DONE;
            e_last = 1'b1;
            if (emit_go) begin
               state_in = part_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = part_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ev_in        = ev_ff;
      oid_in       = oid_ff;
      orep_in      = orep_ff;
      osrv_in      = osrv_ff;
      octx_in      = octx_ff;
      och_in       = och_ff;
      otry_in      = otry_ff;
      olast_in     = olast_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         ev_in        = e_ev;
         oid_in       = e_id;
         orep_in      = e_rep;
         osrv_in      = e_srv;
         octx_in      = e_ctx;
         och_in       = e_ch;
         otry_in      = e_try;
         olast_in     = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= part_pkg::ST_IDLE;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         used_ff      <= '0;
         acked_ff     <= '0;
         id_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         acked_ff     <= acked_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff    <= rq_in;
      ev_ff    <= ev_in;
      oid_ff   <= oid_in;
      orep_ff  <= orep_in;
      osrv_ff  <= osrv_in;
      octx_ff  <= octx_in;
      och_ff   <= och_in;
      otry_ff  <= otry_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = ev_ff;
   assign rsp_ack_id       = oid_ff;
   assign rsp_out_reply_id = orep_ff;
   assign rsp_out_server   = osrv_ff;
   assign rsp_out_context  = octx_ff;
   assign rsp_out_channel  = och_ff;
   assign rsp_try_count    = otry_ff;
   assign rsp_last         = olast_ff;

endmodule
